/* rtl/rmsf_pkg.sv */
// Package for the rolling median spike flagger.
// Shared constants, configuration and item types; no dependencies.
`timescale 1ns / 1ps

package rmsf_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int WIN_AW      = $clog2(WINDOW_MAX);
    localparam int WIN_CW      = $clog2(WINDOW_MAX + 1);
    localparam int SAMPLE_BITS = 24;
    localparam int POS_W       = 20;
    localparam int SUM_W       = 31;
    localparam int SQ_W        = 54;
    localparam int MED_W       = SAMPLE_BITS + 2;
    localparam int RING_W      = SAMPLE_BITS + 1;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = 1;
    localparam int Q_CW        = 2;

    localparam logic [POS_W-1:0]  COUNT_MAX     = '1;
    localparam logic [15:0]       QMASK_RESET   = 16'hFFFF;
    localparam logic [15:0]       BADMASK_RESET = 16'h0000;
    localparam logic [15:0]       THRESH_RESET  = 16'd768;
    localparam logic [6:0]        WSIZE_RESET   = 7'd9;
    localparam logic [WIN_CW-1:0] WIN_MIN       = 3;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_QUALITY_MASK    = 2'd0,
        CFG_BAD_SERIES_MASK = 2'd1,
        CFG_THRESHOLD       = 2'd2,
        CFG_WINDOW_SIZE     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] quality_mask;
        logic [15:0] bad_series_mask;
        logic [15:0] threshold;
        logic [6:0]  window_size;
    } cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          good;
        logic                          start;
        logic                          bad_first;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] centre_index;
        logic             spike;
        logic [POS_W-1:0] flagged_count;
    } result_t;

endpackage

/* rtl/rmsf_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/rmsf_front.sv */
// Front stage: takes input transfers and classifies each sample.
// Depends on rmsf_pkg.
`timescale 1ns / 1ps

module rmsf_front
    import rmsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample[23:0], quality[39:24]
    input  logic [1:0]  s_tuser,   // sample_invalid[0], start_series[1]
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    logic  hold_reg;
    item_t item_reg;
    logic  accept;

    assign s_tready   = !hold_reg || item_ready;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = hold_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            hold_reg <= 1'b0;
        end
    end

    // classification: good sample, series start, bad-series mark
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.sample    <= s_tdata[SAMPLE_BITS-1:0];
            item_reg.good      <= !s_tuser[0] && ((s_tdata[39:24] & cfg.quality_mask) == 16'd0);
            item_reg.start     <= s_tuser[1];
            item_reg.bad_first <= (s_tdata[39:24] & cfg.bad_series_mask) != 16'd0;
        end
    end

endmodule

/* rtl/rmsf_queue.sv */
// Short queue between the front and back stages.
// Depends on rmsf_pkg.
`timescale 1ns / 1ps

module rmsf_queue
    import rmsf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_data
);

    item_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_reg;
    logic [Q_AW-1:0]  rd_reg;
    logic [Q_CW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != Q_CW'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_reg + Q_CW'(do_push) - Q_CW'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue overfilled");

endmodule

/* rtl/rmsf_back.sv */
// Back engine: sorted window, raw and noise rings, exact spike decision.
// Depends on rmsf_pkg and rmsf_ram.
`timescale 1ns / 1ps

module rmsf_back
    import rmsf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  item_t   pop_data,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_READ    = 15'b000000000000010,
        ST_INSERT  = 15'b000000000000100,
        ST_MED_LO  = 15'b000000000001000,
        ST_MED_HI  = 15'b000000000010000,
        ST_J1      = 15'b000000000100000,
        ST_J2      = 15'b000000001000000,
        ST_J3      = 15'b000000010000000,
        ST_J4      = 15'b000000100000000,
        ST_J5      = 15'b000001000000000,
        ST_J6      = 15'b000010000000000,
        ST_OUT     = 15'b000100000000000,
        ST_PUSH1   = 15'b001000000000000,
        ST_PUSH2   = 15'b010000000000000,
        ST_ADVANCE = 15'b100000000000000
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [WIN_CW-1:0] b_reg, b_next;
    logic [WIN_CW-1:0] fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              skip_reg, skip_next;
    logic [WIN_AW-1:0] raw_head_reg, raw_head_next;
    logic [WIN_AW-1:0] noise_head_reg, noise_head_next;
    logic [WIN_CW-1:0] noise_fill_reg, noise_fill_next;
    logic [WIN_CW-1:0] gcnt_reg, gcnt_next;
    logic signed [SUM_W-1:0] nsum_reg, nsum_next;
    logic [SQ_W-1:0]   nsq_reg, nsq_next;
    logic [WIN_CW-1:0] ngood_reg, ngood_next;
    logic              prev_known_reg, prev_known_next;
    logic [POS_W-1:0]  total_reg, total_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic signed [SAMPLE_BITS-1:0] sorted_reg [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] sorted_next [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          good_reg, good_next;
    logic signed [SAMPLE_BITS-1:0] cx_reg, cx_next;
    logic                          cok_reg, cok_next;
    logic signed [SAMPLE_BITS-1:0] old_reg, old_next;
    logic                          old_ok_reg, old_ok_next;
    logic signed [SAMPLE_BITS-1:0] pv_reg, pv_next;
    logic                          pok_reg, pok_next;
    logic signed [SAMPLE_BITS-1:0] med_a_reg, med_a_next;
    logic signed [MED_W-1:0]       m2_reg, m2_next;
    logic signed [MED_W-1:0]       prev_reg, prev_next;
    logic                          mknown_reg, mknown_next;
    logic [26:0]                   abs_d_reg, abs_d_next;
    logic [59:0]                   p2_reg, p2_next;
    logic [31:0]                   t2_reg, t2_next;
    logic                          active_reg, active_next;
    logic [53:0]                   sq_reg, sq_next;
    logic [60:0]                   p1_reg, p1_next;
    logic [60:0]                   v_reg, v_next;
    logic                          vpos_reg, vpos_next;
    logic [65:0]                   left_reg, left_next;
    logic [62:0]                   rlo_reg, rlo_next;
    logic [61:0]                   rhi_reg, rhi_next;
    logic                          spike_reg, spike_next;
    logic [47:0]                   sq_old_reg, sq_old_next;
    logic [47:0]                   sq_new_reg, sq_new_next;
    result_t                       out_reg, out_next;

    // RAM ports
    logic              raw_re, raw_we, noise_re, noise_we;
    logic [WIN_AW-1:0] raw_raddr, slot_addr, noise_raddr;
    logic [RING_W-1:0] raw_rd, slot_rd, noise_rd;

    // series start and first-sample decode
    logic              first;
    logic [WIN_CW-1:0] b_clamp, b_new, am1_new, am1_cur, half_cur;
    logic [WIN_AW-1:0] head_eff, nhead_eff;
    logic [WIN_CW:0]   slot_sum;
    logic              skip_new;

    always_comb
    begin
        first = pop_data.start ||
                (fill_reg == '0 && pos_reg == '0 && !skip_reg);
        if (cfg.window_size < 7'(WIN_MIN))
            b_clamp = WIN_MIN;
        else if (cfg.window_size > 7'(WINDOW_MAX))
            b_clamp = WIN_CW'(WINDOW_MAX);
        else
            b_clamp = WIN_CW'(cfg.window_size);
        b_new     = first ? b_clamp : b_reg;
        skip_new  = (skip_reg && !pop_data.start) || (first && pop_data.bad_first);
        head_eff  = pop_data.start ? '0 : raw_head_reg;
        nhead_eff = pop_data.start ? '0 : noise_head_reg;
        am1_new   = (b_new - 1'b1) >> 1;
        slot_sum  = (WIN_CW+1)'(head_eff) + (WIN_CW+1)'(b_new) - (WIN_CW+1)'(am1_new);
        if (slot_sum >= (WIN_CW+1)'(b_new))
            slot_addr = WIN_AW'(slot_sum - (WIN_CW+1)'(b_new));
        else
            slot_addr = WIN_AW'(slot_sum);
        am1_cur   = (b_reg - 1'b1) >> 1;
        half_cur  = b_reg >> 1;
        raw_raddr   = head_eff;
        noise_raddr = nhead_eff;
    end

    rmsf_ram #(.WIDTH(RING_W), .DEPTH(WINDOW_MAX)) u_raw_ram (
        .clk   (clk),
        .we    (raw_we),
        .waddr (raw_head_reg),
        .wdata ({good_reg, x_reg}),
        .re    (raw_re),
        .raddr (raw_raddr),
        .rdata (raw_rd)
    );

    rmsf_ram #(.WIDTH(RING_W), .DEPTH(WINDOW_MAX)) u_slot_ram (
        .clk   (clk),
        .we    (raw_we),
        .waddr (raw_head_reg),
        .wdata ({good_reg, x_reg}),
        .re    (raw_re),
        .raddr (slot_addr),
        .rdata (slot_rd)
    );

    rmsf_ram #(.WIDTH(RING_W), .DEPTH(WINDOW_MAX)) u_noise_ram (
        .clk   (clk),
        .we    (noise_we),
        .waddr (noise_head_reg),
        .wdata ({pok_reg, pv_reg}),
        .re    (noise_re),
        .raddr (noise_raddr),
        .rdata (noise_rd)
    );

    // sort cells: removal and insertion, with an equal, a greater-or-equal and a less-than compare per cell
    logic signed [SAMPLE_BITS-1:0] rem_v;
    logic [WINDOW_MAX-1:0]         rem_eq, rem_ge, ins_lt;
    logic                          rem_found;
    logic signed [SAMPLE_BITS-1:0] rem_arr [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] ins_arr [WINDOW_MAX];

    always_comb
    begin
        rem_v = raw_rd[SAMPLE_BITS-1:0];
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            rem_eq[i] = (WIN_CW'(i) < gcnt_reg) && (sorted_reg[i] == rem_v);
            rem_ge[i] = (WIN_CW'(i) < gcnt_reg) && (sorted_reg[i] >= rem_v);
            ins_lt[i] = (WIN_CW'(i) < gcnt_reg) && (sorted_reg[i] < x_reg);
        end
        rem_found = |rem_eq;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (i < WINDOW_MAX - 1 && rem_ge[i])
                rem_arr[i] = sorted_reg[(i + 1) % WINDOW_MAX];
            else
                rem_arr[i] = sorted_reg[i];
            if (ins_lt[i])
                ins_arr[i] = sorted_reg[i];
            else if (i == 0 || ins_lt[(i + WINDOW_MAX - 1) % WINDOW_MAX])
                ins_arr[i] = x_reg;
            else
                ins_arr[i] = sorted_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX];
        end
    end

    // median tap and decision arithmetic
    logic [WIN_AW-1:0]       med_half, med_idx;
    logic signed [SAMPLE_BITS-1:0] med_tap;
    logic signed [26:0]      u4;
    logic signed [27:0]      d_val;
    logic [27:0]             d_mag;
    logic [SUM_W-1:0]        s_mag;
    logic [12:0]             k_val;
    logic [95:0]             right_w, left_w;

    always_comb
    begin
        med_half = WIN_AW'(gcnt_reg >> 1);
        med_idx  = (state_reg == ST_MED_LO) ? med_half : med_half - 1'b1;
        med_tap  = sorted_reg[med_idx];
        u4 = prev_known_reg ? (27'(m2_reg) + 27'(prev_reg)) : (27'(m2_reg) <<< 1);
        d_val = (28'(cx_reg) <<< 2) - 28'(u4);
        d_mag = d_val[27] ? 28'(-d_val) : 28'(d_val);
        s_mag = nsum_reg[SUM_W-1] ? SUM_W'(-nsum_reg) : SUM_W'(nsum_reg);
        k_val = 13'(ngood_reg) * 13'(ngood_reg - 1'b1);
        right_w = (96'(rhi_reg) << 31) + 96'(rlo_reg);
        left_w  = 96'(left_reg) << 12;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        b_next          = b_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        skip_next       = skip_reg;
        raw_head_next   = raw_head_reg;
        noise_head_next = noise_head_reg;
        noise_fill_next = noise_fill_reg;
        gcnt_next       = gcnt_reg;
        nsum_next       = nsum_reg;
        nsq_next        = nsq_reg;
        ngood_next      = ngood_reg;
        prev_known_next = prev_known_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sorted_next     = sorted_reg;
        x_next          = x_reg;
        good_next       = good_reg;
        cx_next         = cx_reg;
        cok_next        = cok_reg;
        old_next        = old_reg;
        old_ok_next     = old_ok_reg;
        pv_next         = pv_reg;
        pok_next        = pok_reg;
        med_a_next      = med_a_reg;
        m2_next         = m2_reg;
        prev_next       = prev_reg;
        mknown_next     = mknown_reg;
        abs_d_next      = abs_d_reg;
        p2_next         = p2_reg;
        t2_next         = t2_reg;
        active_next     = active_reg;
        sq_next         = sq_reg;
        p1_next         = p1_reg;
        v_next          = v_reg;
        vpos_next       = vpos_reg;
        left_next       = left_reg;
        rlo_next        = rlo_reg;
        rhi_next        = rhi_reg;
        spike_next      = spike_reg;
        sq_old_next     = sq_old_reg;
        sq_new_next     = sq_new_reg;
        out_next        = out_reg;
        pop_ready       = 1'b0;
        raw_re          = 1'b0;
        raw_we          = 1'b0;
        noise_re        = 1'b0;
        noise_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    pop_ready = 1'b1;
                    if (pop_data.start)
                    begin
                        fill_next       = '0;
                        pos_next        = '0;
                        raw_head_next   = '0;
                        noise_head_next = '0;
                        noise_fill_next = '0;
                        gcnt_next       = '0;
                        nsum_next       = '0;
                        nsq_next        = '0;
                        ngood_next      = '0;
                        prev_known_next = 1'b0;
                        total_next      = '0;
                    end
                    b_next    = b_new;
                    skip_next = skip_new;
                    x_next    = pop_data.sample;
                    good_next = pop_data.good;
                    if (!skip_new)
                    begin
                        raw_re     = 1'b1;
                        noise_re   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // drop the sample leaving the window, store the new one
                if (fill_reg >= b_reg && raw_rd[SAMPLE_BITS] && rem_found)
                begin
                    sorted_next = rem_arr;
                    gcnt_next   = gcnt_reg - 1'b1;
                end
                raw_we      = 1'b1;
                cx_next     = slot_rd[SAMPLE_BITS-1:0];
                cok_next    = slot_rd[SAMPLE_BITS];
                old_next    = noise_rd[SAMPLE_BITS-1:0];
                old_ok_next = noise_rd[SAMPLE_BITS] &&
                              (WIN_CW'(noise_head_reg) < noise_fill_reg);
                state_next  = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (good_reg && gcnt_reg < WIN_CW'(WINDOW_MAX))
                begin
                    sorted_next = ins_arr;
                    gcnt_next   = gcnt_reg + 1'b1;
                end
                if (fill_reg + 1'b1 >= b_reg)
                    state_next = ST_MED_LO;
                else if (fill_reg < half_cur)
                begin
                    pv_next    = x_reg;
                    pok_next   = good_reg;
                    state_next = ST_PUSH1;
                end
                else
                    state_next = ST_ADVANCE;
            end
            ST_MED_LO:
            begin
                med_a_next = med_tap;
                state_next = ST_MED_HI;
            end
            ST_MED_HI:
            begin
                mknown_next = gcnt_reg != '0;
                if (gcnt_reg == '0)
                    m2_next = '0;
                else if (gcnt_reg[0])
                    m2_next = MED_W'(med_a_reg) <<< 1;
                else
                    m2_next = MED_W'(med_a_reg) + MED_W'(med_tap);
                state_next = ST_J1;
            end
            ST_J1:
            begin
                abs_d_next  = d_mag[26:0];
                p2_next     = s_mag[29:0] * s_mag[29:0];
                t2_next     = cfg.threshold * cfg.threshold;
                active_next = cok_reg && mknown_reg && (cfg.threshold != 16'd0) &&
                              (ngood_reg >= WIN_CW'(4));
                state_next  = ST_J2;
            end
            ST_J2:
            begin
                sq_next    = abs_d_reg * abs_d_reg;
                p1_next    = 61'(ngood_reg) * 61'(nsq_reg);
                state_next = ST_J3;
            end
            ST_J3:
            begin
                vpos_next  = p1_reg > 61'(p2_reg);
                v_next     = p1_reg - 61'(p2_reg);
                left_next  = 66'(sq_reg) * 66'(k_val);
                state_next = ST_J4;
            end
            ST_J4:
            begin
                rlo_next   = 63'(t2_reg) * 63'(v_reg[30:0]);
                state_next = ST_J5;
            end
            ST_J5:
            begin
                rhi_next   = 62'(t2_reg) * 62'(v_reg[60:31]);
                state_next = ST_J6;
            end
            ST_J6:
            begin
                spike_next = active_reg && vpos_reg && (left_w > right_w);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    if (spike_reg && total_reg < COUNT_MAX)
                        total_next = total_reg + 1'b1;
                    out_next.centre_index  = pos_reg - POS_W'(am1_cur);
                    out_next.spike         = spike_reg;
                    out_next.flagged_count = total_next;
                    out_valid_next  = 1'b1;
                    prev_next       = m2_reg;
                    prev_known_next = mknown_reg;
                    pv_next         = cx_reg;
                    pok_next        = cok_reg && !spike_reg;
                    state_next      = ST_PUSH1;
                end
            end
            ST_PUSH1:
            begin
                sq_old_next = 48'(old_reg * old_reg);
                sq_new_next = 48'(pv_reg * pv_reg);
                state_next  = ST_PUSH2;
            end
            ST_PUSH2:
            begin
                // retire the oldest noise entry and add the new one
                nsum_next  = nsum_reg - (old_ok_reg ? SUM_W'(old_reg) : '0)
                                      + (pok_reg ? SUM_W'(pv_reg) : '0);
                nsq_next   = nsq_reg - (old_ok_reg ? SQ_W'(sq_old_reg) : '0)
                                     + (pok_reg ? SQ_W'(sq_new_reg) : '0);
                ngood_next = ngood_reg - WIN_CW'(old_ok_reg) + WIN_CW'(pok_reg);
                noise_we   = 1'b1;
                if (WIN_CW'(noise_head_reg) + 1'b1 >= b_reg)
                    noise_head_next = '0;
                else
                    noise_head_next = noise_head_reg + 1'b1;
                if (noise_fill_reg < b_reg)
                    noise_fill_next = noise_fill_reg + 1'b1;
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE:
            begin
                if (WIN_CW'(raw_head_reg) + 1'b1 >= b_reg)
                    raw_head_next = '0;
                else
                    raw_head_next = raw_head_reg + 1'b1;
                if (fill_reg < b_reg)
                    fill_next = fill_reg + 1'b1;
                pos_next   = pos_reg + 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            b_reg          <= WSIZE_RESET;
            fill_reg       <= '0;
            pos_reg        <= '0;
            skip_reg       <= 1'b0;
            raw_head_reg   <= '0;
            noise_head_reg <= '0;
            noise_fill_reg <= '0;
            gcnt_reg       <= '0;
            nsum_reg       <= '0;
            nsq_reg        <= '0;
            ngood_reg      <= '0;
            prev_known_reg <= 1'b0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            b_reg          <= b_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            skip_reg       <= skip_next;
            raw_head_reg   <= raw_head_next;
            noise_head_reg <= noise_head_next;
            noise_fill_reg <= noise_fill_next;
            gcnt_reg       <= gcnt_next;
            nsum_reg       <= nsum_next;
            nsq_reg        <= nsq_next;
            ngood_reg      <= ngood_next;
            prev_known_reg <= prev_known_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sorted_reg <= sorted_next;
        x_reg      <= x_next;
        good_reg   <= good_next;
        cx_reg     <= cx_next;
        cok_reg    <= cok_next;
        old_reg    <= old_next;
        old_ok_reg <= old_ok_next;
        pv_reg     <= pv_next;
        pok_reg    <= pok_next;
        med_a_reg  <= med_a_next;
        m2_reg     <= m2_next;
        prev_reg   <= prev_next;
        mknown_reg <= mknown_next;
        abs_d_reg  <= abs_d_next;
        p2_reg     <= p2_next;
        t2_reg     <= t2_next;
        active_reg <= active_next;
        sq_reg     <= sq_next;
        p1_reg     <= p1_next;
        v_reg      <= v_next;
        vpos_reg   <= vpos_next;
        left_reg   <= left_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        spike_reg  <= spike_next;
        sq_old_reg <= sq_old_next;
        sq_new_reg <= sq_new_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= b_reg && noise_fill_reg <= b_reg)
        else $error("fill count beyond window");

    a_sort_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= WIN_CW'(WINDOW_MAX) && ngood_reg <= b_reg)
        else $error("good count beyond capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WIN_CW'(raw_head_reg) < b_reg && WIN_CW'(noise_head_reg) < b_reg)
        else $error("ring pointer beyond window");

endmodule

/* rtl/rolling_median_spike_flagger_unit.sv */
// Top level of the rolling median spike flagger.
// Depends on rmsf_pkg, rmsf_front, rmsf_queue, rmsf_back (and rmsf_ram).
`timescale 1ns / 1ps

// Flags spikes in one detector series against a rolling median and a lagged
// noise deviation. Each sample travels through a classifying front stage and
// a two-entry queue into a sequential back engine. Every sample passes the
// engine's ring RAM read, one sort-cell update each for removal and insertion
// and the ring advance; one that also enters the noise ring adds the noise
// push, and one that completes a window and yields a result adds a two-step
// median tap, a six-step exact squared compare and a wait for the output register.
// A sample of a skipped series is taken and dropped in idle. Window size is latched on
// the first sample of each series.

module rolling_median_spike_flagger_unit
    import rmsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample[23:0], quality[39:24]
    input  logic [1:0]  s_tuser,   // sample_invalid[0], start_series[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // centre_index[19:0], flagged_count[39:20]
    output logic [0:0]  m_tuser    // spike[0]
);

    cfg_t    cfg_reg;
    logic    f_valid, f_ready, q_valid, q_ready;
    item_t   f_item, q_item;
    result_t res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quality_mask    <= QMASK_RESET;
            cfg_reg.bad_series_mask <= BADMASK_RESET;
            cfg_reg.threshold       <= THRESH_RESET;
            cfg_reg.window_size     <= WSIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_QUALITY_MASK:    cfg_reg.quality_mask    <= cfg_data;
                CFG_BAD_SERIES_MASK: cfg_reg.bad_series_mask <= cfg_data;
                CFG_THRESHOLD:       cfg_reg.threshold       <= cfg_data;
                CFG_WINDOW_SIZE:     cfg_reg.window_size     <= cfg_data[6:0];
            endcase
        end
    end

    rmsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    rmsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    rmsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_item),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

    assign m_tdata = {res.flagged_count, res.centre_index};
    assign m_tuser = res.spike;

endmodule
